// ===== sv/reply_frame_checker_decoder_defines.svh =====
// Assertion helpers for use in files that check their own logic.
// Both expect a clock named clk and an active-low reset named arst_n.
`ifndef REPLY_FRAME_CHECKER_DECODER_DEFINES_SVH
`define REPLY_FRAME_CHECKER_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rfcd_pkg.sv =====
package rfcd_pkg;

	// Frame geometry.
	localparam int PAYLOAD_BYTES = 60;
	localparam int PAY_AW = $clog2(PAYLOAD_BYTES);
	localparam int CNT_W = 7;

	localparam logic [CNT_W-1:0] POS_ADDR = CNT_W'(4);
	localparam logic [CNT_W-1:0] POS_PAGE = CNT_W'(5);
	localparam logic [CNT_W-1:0] POS_LEN_HI = CNT_W'(6);
	localparam logic [CNT_W-1:0] POS_LEN_LO = CNT_W'(7);
	localparam logic [CNT_W-1:0] POS_PAYLOAD = CNT_W'(8);
	localparam logic [CNT_W-1:0] CRC_POS = CNT_W'(PAYLOAD_BYTES + 8);
	localparam logic [CNT_W-1:0] TAIL_POS = CNT_W'(PAYLOAD_BYTES + 10);
	localparam logic [CNT_W-1:0] FRAME_BYTES = CNT_W'(PAYLOAD_BYTES + 14);
	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(PAYLOAD_BYTES + 15);

	localparam logic [7:0] LEN_HI = 8'((PAYLOAD_BYTES >> 8) & 255);
	localparam logic [7:0] LEN_LO = 8'(PAYLOAD_BYTES & 255);
	localparam logic [PAY_AW-1:0] PAY_LAST_ADDR = PAY_AW'(PAYLOAD_BYTES - 1);

	// CRC-16 polynomial, MSB first.
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Measurement layout: fields are packed back to back over the payload.
	// A set bit marks a 32-bit field, a clear bit a 16-bit field.
	localparam int NUM_FIELDS = 21;
	localparam int FIDX_W = 5;
	localparam logic [FIDX_W-1:0] LAST_FIELD = FIDX_W'(NUM_FIELDS - 1);
	localparam logic [NUM_FIELDS-1:0] WIDE_MASK = 21'h0C01E7;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MARKER0 = 3'd0,
		REG_MARKER1 = 3'd1,
		REG_MARKER2 = 3'd2,
		REG_MARKER3 = 3'd3,
		REG_DEV_ADDR = 3'd4,
		REG_PAGE = 3'd5
	} cfg_reg_t;

	// Byte sequencer states.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_HI = 4'b0010,
		S_LO = 4'b0100,
		S_DONE = 4'b1000
	} byte_state_t;

	// Result unpacker states.
	typedef enum logic [3:0] {
		E_IDLE = 4'b0001,
		E_FAIL = 4'b0010,
		E_FETCH = 4'b0100,
		E_PUSH = 4'b1000
	} emit_state_t;

	// Control of the nibble-serial CRC unit.
	typedef struct packed {
		logic load;
		logic en;
		logic step;
		logic clear;
	} crc_ctrl_t;

	// Frame verdict handed to the result unpacker.
	typedef struct packed {
		logic start;
		logic good;
	} emit_cmd_t;

endpackage

// ===== sv/rfcd_in_if.sv =====
interface rfcd_in_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	logic frame_end;

	modport source(output valid, output rx_byte, output frame_end, input ready);
	modport sink(input valid, input rx_byte, input frame_end, output ready);
endinterface

// ===== sv/rfcd_out_if.sv =====
interface rfcd_out_if;
	logic valid;
	logic ready;
	logic [4:0] field_index;
	logic [31:0] field_value;
	logic frame_ok;
	logic last_result;

	modport source(output valid, output field_index, output field_value,
		output frame_ok, output last_result, input ready);
	modport sink(input valid, input field_index, input field_value,
		input frame_ok, input last_result, output ready);
endinterface

// ===== sv/rfcd_ram.sv =====
module rfcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 60
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/rfcd_crc.sv =====
module rfcd_crc
	import rfcd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input crc_ctrl_t ctrl,
	input logic [7:0] data,
	output logic [15:0] crc
);

	logic [7:0] sh_q;
	logic en_q;
	logic [15:0] crc_q;

	// Four MSB-first CRC steps over one nibble.
	function automatic logic [15:0] crc_nibble(input logic [15:0] c_in, input logic [3:0] d);
		logic [15:0] c;
		c = c_in;
		for (int i = 0; i < 4; i++) begin
			if (c[15] ^ d[3-i]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Byte shift register: loads a byte, then hands out its nibbles high first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= '0;
			en_q <= 1'b0;
		end else if (ctrl.load) begin
			sh_q <= data;
			en_q <= ctrl.en;
		end else if (ctrl.step) begin
			sh_q <= {sh_q[3:0], 4'b0000};
		end
	end

	// Running CRC, advanced one nibble per step for bytes inside the covered range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (ctrl.clear) begin
			crc_q <= '0;
		end else if (ctrl.step && en_q) begin
			crc_q <= crc_nibble(crc_q, sh_q[7:4]);
		end
	end

	assign crc = crc_q;

endmodule

// ===== sv/rfcd_unpack.sv =====
module rfcd_unpack
	import rfcd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input emit_cmd_t cmd,
	output logic busy,
	output logic rd_en,
	output logic [PAY_AW-1:0] rd_addr,
	input logic [7:0] rd_data,
	rfcd_out_if.source res
);

	emit_state_t est_q;
	logic [FIDX_W-1:0] field_q;
	logic [PAY_AW-1:0] addr_q;
	logic [2:0] issued_q;
	logic [2:0] got_q;
	logic rd_vld_s1;
	logic [31:0] val_q;

	logic ov_q;
	logic [FIDX_W-1:0] oidx_q;
	logic [31:0] oval_q;
	logic ook_q;
	logic olast_q;

	logic [2:0] size;
	logic out_free;
	logic load_fail;
	logic load_field;

	// Field size in bytes, from the layout mask.
	assign size = WIDE_MASK[field_q] ? 3'd4 : 3'd2;
	assign out_free = !ov_q || res.ready;
	assign rd_en = (est_q == E_FETCH) && (issued_q != size);
	assign rd_addr = addr_q;
	assign load_fail = (est_q == E_FAIL) && out_free;
	assign load_field = (est_q == E_PUSH) && out_free;
	assign busy = (est_q != E_IDLE);

	// Walks the payload in order, one byte per cycle while fetching, one field at a time; a busy output stalls it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= E_IDLE;
			field_q <= '0;
			addr_q <= '0;
			issued_q <= '0;
			got_q <= '0;
			rd_vld_s1 <= 1'b0;
			val_q <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			unique case (est_q)
				E_IDLE: begin
					if (cmd.start) begin
						field_q <= '0;
						addr_q <= '0;
						issued_q <= '0;
						got_q <= '0;
						val_q <= '0;
						est_q <= cmd.good ? E_FETCH : E_FAIL;
					end
				end
				E_FAIL: begin
					if (out_free) begin
						est_q <= E_IDLE;
					end
				end
				E_FETCH: begin
					if (rd_en) begin
						addr_q <= addr_q + PAY_AW'(1);
						issued_q <= issued_q + 3'd1;
					end
					if (rd_vld_s1) begin
						val_q <= {val_q[23:0], rd_data};
						got_q <= got_q + 3'd1;
						if (got_q == size - 3'd1) begin
							est_q <= E_PUSH;
						end
					end
				end
				E_PUSH: begin
					if (out_free) begin
						field_q <= field_q + FIDX_W'(1);
						issued_q <= '0;
						got_q <= '0;
						val_q <= '0;
						est_q <= (field_q == LAST_FIELD) ? E_IDLE : E_FETCH;
					end
				end
				default: begin
					est_q <= E_IDLE;
				end
			endcase
		end
	end

	// Output register: holds one result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_fail || load_field) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_fail) begin
			oidx_q <= '0;
			oval_q <= '0;
			ook_q <= 1'b0;
			olast_q <= 1'b1;
		end else if (load_field) begin
			oidx_q <= field_q;
			oval_q <= val_q;
			ook_q <= 1'b1;
			olast_q <= (field_q == LAST_FIELD);
		end
	end

	assign res.valid = ov_q;
	assign res.field_index = oidx_q;
	assign res.field_value = oval_q;
	assign res.frame_ok = ook_q;
	assign res.last_result = olast_q;

endmodule

// ===== sv/reply_frame_checker_decoder.sv =====
// Reply frame checker and decoder. Bytes of a 74-byte reply frame enter on rx, one item
// each, with frame_end set on the final byte. Each byte is checked as it arrives against
// the start markers, device address, page code and fixed length; payload bytes go to a
// 60-entry memory and the CRC-16 (0x1021, initial value 0) is built a nibble per cycle;
// rx takes the next item during the previous one's low nibble. A rejected frame gives
// one result with frame_ok low; an accepted frame gives 21 results, field_index 0 to 20
// with big-endian values, read back from the memory one byte per cycle while a field is
// fetched, held while res stalls. rx is held off until the last result is in the output
// register. Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata by the user only while no frame is in progress; the block does not enforce it.
`include "reply_frame_checker_decoder_defines.svh"

module reply_frame_checker_decoder
	import rfcd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	rfcd_in_if.sink rx,
	rfcd_out_if.source res,
	input logic cfg_wr_en,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_wdata
);

	logic [7:0] marker_q [4];
	logic [7:0] dev_addr_q;
	logic [7:0] page_q;

	byte_state_t st_q;
	logic [CNT_W-1:0] count_q;
	logic err_q;
	logic [15:0] rcrc_q;
	logic end_q;

	logic accept;
	logic emit_busy;
	logic [1:0] mk_sel;
	logic [7:0] mk_exp;
	logic byte_bad;
	logic pay_wr_en;
	logic [PAY_AW-1:0] pay_wr_addr;
	logic [CNT_W-1:0] pay_off;
	logic [15:0] rcrc_d;
	logic [15:0] crc_val;
	logic pay_rd_en;
	logic [PAY_AW-1:0] pay_rd_addr;
	logic [7:0] pay_rd_data;
	crc_ctrl_t crc_ctrl;
	emit_cmd_t emit_cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q[0] <= '0;
			marker_q[1] <= '0;
			marker_q[2] <= '0;
			marker_q[3] <= '0;
			dev_addr_q <= '0;
			page_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MARKER0: marker_q[0] <= cfg_wdata;
				REG_MARKER1: marker_q[1] <= cfg_wdata;
				REG_MARKER2: marker_q[2] <= cfg_wdata;
				REG_MARKER3: marker_q[3] <= cfg_wdata;
				REG_DEV_ADDR: dev_addr_q <= cfg_wdata;
				REG_PAGE: page_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// With the unpacker idle, a byte is taken when idle or while a non-final byte finishes its low nibble.
	assign rx.ready = !emit_busy && ((st_q == S_IDLE) || ((st_q == S_LO) && !end_q));
	assign accept = rx.valid && rx.ready;

	// One marker lookup serves both the head and the tail of the frame.
	assign mk_sel = (count_q < POS_ADDR) ? count_q[1:0] : (count_q[1:0] - TAIL_POS[1:0]);
	assign mk_exp = marker_q[mk_sel];
	assign pay_off = count_q - POS_PAYLOAD;
	assign pay_wr_addr = pay_off[PAY_AW-1:0];

	// Per-position check of the incoming byte.
	always_comb begin
		byte_bad = 1'b0;
		pay_wr_en = 1'b0;
		rcrc_d = rcrc_q;
		if (count_q < POS_ADDR) begin
			byte_bad = (rx.rx_byte != mk_exp);
		end else if (count_q == POS_ADDR) begin
			byte_bad = (rx.rx_byte != dev_addr_q);
		end else if (count_q == POS_PAGE) begin
			byte_bad = (rx.rx_byte != page_q);
		end else if (count_q == POS_LEN_HI) begin
			byte_bad = (rx.rx_byte != LEN_HI);
		end else if (count_q == POS_LEN_LO) begin
			byte_bad = (rx.rx_byte != LEN_LO);
		end else if (count_q < CRC_POS) begin
			pay_wr_en = accept;
		end else if (count_q == CRC_POS) begin
			rcrc_d = {rx.rx_byte, rcrc_q[7:0]};
		end else if (count_q == CRC_POS + CNT_W'(1)) begin
			rcrc_d = {rcrc_q[15:8], rx.rx_byte};
		end else if (count_q < FRAME_BYTES) begin
			byte_bad = (rx.rx_byte != mk_exp);
		end else begin
			byte_bad = 1'b1;
		end
	end

	// Byte sequencer and per-frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			count_q <= '0;
			err_q <= 1'b0;
			rcrc_q <= '0;
			end_q <= 1'b0;
		end else begin
			if (accept) begin
				err_q <= err_q | byte_bad;
				rcrc_q <= rcrc_d;
				end_q <= rx.frame_end;
				if (count_q < COUNT_MAX) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						st_q <= S_HI;
					end
				end
				S_HI: begin
					st_q <= S_LO;
				end
				S_LO: begin
					if (accept) begin
						st_q <= S_HI;
					end else if (end_q) begin
						st_q <= S_DONE;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_DONE: begin
					count_q <= '0;
					err_q <= 1'b0;
					rcrc_q <= '0;
					end_q <= 1'b0;
					st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// CRC unit control.
	assign crc_ctrl.load = accept;
	assign crc_ctrl.en = (count_q < CRC_POS);
	assign crc_ctrl.step = (st_q == S_HI) || (st_q == S_LO);
	assign crc_ctrl.clear = (st_q == S_DONE);

	rfcd_crc u_crc (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(crc_ctrl),
		.data(rx.rx_byte),
		.crc(crc_val)
	);

	// Frame verdict once the last byte has gone through the CRC.
	assign emit_cmd.start = (st_q == S_DONE);
	assign emit_cmd.good = !err_q && (count_q == FRAME_BYTES) && (crc_val == rcrc_q);

	rfcd_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_BYTES)
	) u_payload (
		.clk(clk),
		.wr_en(pay_wr_en),
		.wr_addr(pay_wr_addr),
		.wr_data(rx.rx_byte),
		.rd_en(pay_rd_en),
		.rd_addr(pay_rd_addr),
		.rd_data(pay_rd_data)
	);

	rfcd_unpack u_unpack (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(emit_cmd),
		.busy(emit_busy),
		.rd_en(pay_rd_en),
		.rd_addr(pay_rd_addr),
		.rd_data(pay_rd_data),
		.res(res)
	);

	// Checks on the block's own logic.
	`RFCD_ASSERT_NOW(a_ram_port, pay_wr_en, !pay_rd_en, "payload written while being read back")
	`RFCD_ASSERT_NOW(a_wr_range, pay_wr_en, pay_wr_addr <= PAY_LAST_ADDR, "payload write out of range")
	`RFCD_ASSERT_NOW(a_fail_form, res.valid && !res.frame_ok, res.last_result && res.field_index == '0 && res.field_value == '0, "malformed failure item")
	`RFCD_ASSERT_NEXT(a_frame_clear, st_q == S_DONE, count_q == '0 && !err_q && !end_q, "frame state not cleared")

endmodule
